### hdl/mpm_pkg.sv
package mpm_pkg;

  // sizing of the trie and the tables
  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 26;
  localparam int NODE_W    = 10;
  localparam int NTOT_W    = 11;
  localparam int LET_W     = 5;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 16;
  localparam int TOT_W     = 48;
  localparam int TAB_DEPTH = MAX_NODES * ALPHABET;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  // command codes
  localparam logic [CMD_W-1:0] CMD_PLET  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BUILD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TEXT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LET_W-1:0] letter;
    logic             last_of_text;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  matches_here;
    logic [TOT_W-1:0]  running_total;
    logic [NTOT_W-1:0] nodes_used;
  } out_res_t;

  // per-node data written by the build walk
  typedef struct packed {
    logic [NODE_W-1:0] fail;
    logic [CNT_W-1:0]  out_cnt;
  } node_info_t;

  // flat index of a (node, letter) edge
  function automatic logic [TAB_AW-1:0] slot_addr(input logic [NODE_W-1:0] node,
                                                  input logic [LET_W-1:0] let_i);
    logic [TAB_AW-1:0] prod;
    prod = TAB_AW'(node) * TAB_AW'(ALPHABET);
    return prod + TAB_AW'(let_i);
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + (TOT_W+1)'(b);
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

### hdl/mpm_ram.sv
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/multi_pattern_match_counter.sv
// steps: pattern letter P_RD, P_CHK; pattern end E_RD, E_WR; text T_GO, T_INFO, T_ACC
// throughput: one request at a time, the next is taken once the result is registered;
//   text letters are bound by two dependent table reads (goto entry, then output count)
// build: each edge of every trie node passes B_RD and B_EDGE, and B_LINK for a real child
// reset and clear: a pass over all 26624 child entries zeroes the child and end count tables,
//   no request is taken meanwhile
module multi_pattern_match_counter
  import mpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  localparam int SW = 5;
  localparam logic [SW-1:0] S_IDLE   = 5'd0;
  localparam logic [SW-1:0] S_CLR    = 5'd1;
  localparam logic [SW-1:0] S_DONE   = 5'd2;
  localparam logic [SW-1:0] S_P_RD   = 5'd3;
  localparam logic [SW-1:0] S_P_CHK  = 5'd4;
  localparam logic [SW-1:0] S_E_RD   = 5'd5;
  localparam logic [SW-1:0] S_E_WR   = 5'd6;
  localparam logic [SW-1:0] S_T_GO   = 5'd7;
  localparam logic [SW-1:0] S_T_INFO = 5'd8;
  localparam logic [SW-1:0] S_T_ACC  = 5'd9;
  localparam logic [SW-1:0] S_B_INIT = 5'd10;
  localparam logic [SW-1:0] S_B_RD   = 5'd11;
  localparam logic [SW-1:0] S_B_EDGE = 5'd12;
  localparam logic [SW-1:0] S_B_LINK = 5'd13;
  localparam logic [SW-1:0] S_B_POP  = 5'd14;
  localparam logic [SW-1:0] S_B_U    = 5'd15;
  localparam logic [SW-1:0] S_B_FU   = 5'd16;

  localparam logic [LET_W-1:0]  LAST_LET  = LET_W'(ALPHABET - 1);
  localparam logic [LET_W-1:0]  NUM_LET   = LET_W'(ALPHABET);
  localparam logic [NTOT_W-1:0] NODE_LIM  = NTOT_W'(MAX_NODES);
  localparam logic [TAB_AW-1:0] CLR_LAST  = TAB_AW'(TAB_DEPTH - 1);
  localparam logic [TAB_AW-1:0] CLR_NODES = TAB_AW'(MAX_NODES);

  logic [SW-1:0]     state_r, state_nxt;
  logic [LET_W-1:0]  letter_r, letter_nxt;
  logic              last_r, last_nxt;
  logic [NTOT_W-1:0] node_total_r, node_total_nxt;
  logic [NODE_W-1:0] insert_r, insert_nxt;
  logic [NODE_W-1:0] match_r, match_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              built_r, built_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CNT_W-1:0]  here_r, here_nxt;
  logic [TOT_W-1:0]  rep_total_r, rep_total_nxt;
  logic [TAB_AW-1:0] clr_r, clr_nxt;
  logic              clr_rep_r, clr_rep_nxt;
  logic [NTOT_W-1:0] head_r, head_nxt;
  logic [NTOT_W-1:0] tail_r, tail_nxt;
  logic [LET_W-1:0]  j_r, j_nxt;
  logic              root_r, root_nxt;
  logic [NODE_W-1:0] u_r, u_nxt;
  logic [NODE_W-1:0] fu_r, fu_nxt;
  logic [NODE_W-1:0] c_r, c_nxt;
  logic [NODE_W-1:0] via_r, via_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_data_r, out_data_nxt;

  // table ports
  logic              child_we, goto_we, endc_we, info_we, queue_we;
  logic [TAB_AW-1:0] child_wa, child_ra, goto_wa, goto_ra;
  logic [NODE_W-1:0] child_wd, child_rd, goto_wd, goto_rd;
  logic [NODE_W-1:0] endc_wa, endc_ra, info_wa, info_ra, queue_wa, queue_ra;
  logic [CNT_W-1:0]  endc_wd, endc_rd;
  node_info_t        info_wd, info_rd;
  logic [NODE_W-1:0] queue_wd, queue_rd;

  logic              accept;
  logic              out_free;
  logic [NODE_W-1:0] via_sel;
  logic [TOT_W-1:0]  sum_tot;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign via_sel  = root_r ? '0 : goto_rd;
  assign sum_tot  = sat_tot(total_r, info_rd.out_cnt);

  mpm_ram #(.WIDTH(NODE_W), .DEPTH(TAB_DEPTH)) u_child (
    .clk(clk), .wr_en(child_we), .wr_addr(child_wa), .wr_data(child_wd),
    .rd_addr(child_ra), .rd_data(child_rd)
  );

  mpm_ram #(.WIDTH(NODE_W), .DEPTH(TAB_DEPTH)) u_goto (
    .clk(clk), .wr_en(goto_we), .wr_addr(goto_wa), .wr_data(goto_wd),
    .rd_addr(goto_ra), .rd_data(goto_rd)
  );

  mpm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_endc (
    .clk(clk), .wr_en(endc_we), .wr_addr(endc_wa), .wr_data(endc_wd),
    .rd_addr(endc_ra), .rd_data(endc_rd)
  );

  mpm_ram #(.WIDTH($bits(node_info_t)), .DEPTH(MAX_NODES)) u_info (
    .clk(clk), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
    .rd_addr(info_ra), .rd_data(info_rd)
  );

  mpm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .wr_en(queue_we), .wr_addr(queue_wa), .wr_data(queue_wd),
    .rd_addr(queue_ra), .rd_data(queue_rd)
  );

  // sequencer: command handling, build walk and clearing pass
  always_comb begin
    state_nxt      = state_r;
    letter_nxt     = letter_r;
    last_nxt       = last_r;
    node_total_nxt = node_total_r;
    insert_nxt     = insert_r;
    match_nxt      = match_r;
    total_nxt      = total_r;
    built_nxt      = built_r;
    status_nxt     = status_r;
    here_nxt       = here_r;
    rep_total_nxt  = rep_total_r;
    clr_nxt        = clr_r;
    clr_rep_nxt    = clr_rep_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    j_nxt          = j_r;
    root_nxt       = root_r;
    u_nxt          = u_r;
    fu_nxt         = fu_r;
    c_nxt          = c_r;
    via_nxt        = via_r;
    out_valid_nxt  = out_stall ? out_valid_r : 1'b0;
    out_data_nxt   = out_data_r;

    child_we = 1'b0; child_wa = '0; child_wd = '0; child_ra = '0;
    goto_we  = 1'b0; goto_wa  = '0; goto_wd  = '0; goto_ra  = '0;
    endc_we  = 1'b0; endc_wa  = '0; endc_wd  = '0; endc_ra  = '0;
    info_we  = 1'b0; info_wa  = '0; info_wd  = '0; info_ra  = '0;
    queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_ra = '0;

    unique case (state_r)
      // take a request and dispatch on its command
      S_IDLE: begin
        if (accept) begin
          letter_nxt    = in_data.letter;
          last_nxt      = in_data.last_of_text;
          status_nxt    = ST_OK;
          here_nxt      = '0;
          rep_total_nxt = total_r;
          case (in_data.cmd)
            CMD_PLET: begin
              built_nxt = 1'b0;
              state_nxt = (in_data.letter < NUM_LET) ? S_P_RD : S_DONE;
            end
            CMD_PEND: begin
              built_nxt = 1'b0;
              state_nxt = S_E_RD;
            end
            CMD_BUILD: begin
              state_nxt = S_B_INIT;
            end
            CMD_TEXT: begin
              if (!built_r) begin
                status_nxt = ST_NOT_BUILT;
                state_nxt  = S_DONE;
              end else if (in_data.letter < NUM_LET) begin
                state_nxt = S_T_GO;
              end else begin
                // out-of-alphabet letter: back to root, nothing counted
                match_nxt = '0;
                if (in_data.last_of_text) begin
                  total_nxt = '0;
                end
                state_nxt = S_DONE;
              end
            end
            CMD_CLEAR: begin
              node_total_nxt = NTOT_W'(1);
              insert_nxt     = '0;
              match_nxt      = '0;
              total_nxt      = '0;
              built_nxt      = 1'b0;
              rep_total_nxt  = '0;
              clr_nxt        = '0;
              clr_rep_nxt    = 1'b1;
              state_nxt      = S_CLR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // zero child and end count tables one entry a cycle
      S_CLR: begin
        child_we = 1'b1;
        child_wa = clr_r;
        if (clr_r < CLR_NODES) begin
          endc_we = 1'b1;
          endc_wa = clr_r[NODE_W-1:0];
        end
        if (clr_r == CLR_LAST) begin
          state_nxt = clr_rep_r ? S_DONE : S_IDLE;
        end else begin
          clr_nxt = clr_r + TAB_AW'(1);
        end
      end

      // pattern letter: look up the child edge
      S_P_RD: begin
        child_ra  = slot_addr(insert_r, letter_r);
        state_nxt = S_P_CHK;
      end

      S_P_CHK: begin
        if (child_rd != '0) begin
          insert_nxt = child_rd;
        end else if (node_total_r < NODE_LIM) begin
          child_we       = 1'b1;
          child_wa       = slot_addr(insert_r, letter_r);
          child_wd       = node_total_r[NODE_W-1:0];
          insert_nxt     = node_total_r[NODE_W-1:0];
          node_total_nxt = node_total_r + NTOT_W'(1);
        end else begin
          status_nxt = ST_FULL;
        end
        state_nxt = S_DONE;
      end

      // end of pattern: bump end count of the insertion node
      S_E_RD: begin
        endc_ra   = insert_r;
        state_nxt = S_E_WR;
      end

      S_E_WR: begin
        endc_we    = 1'b1;
        endc_wa    = insert_r;
        endc_wd    = sat_cnt(endc_rd, CNT_W'(1));
        insert_nxt = '0;
        state_nxt  = S_DONE;
      end

      // text letter: goto step, then output count of the new node
      S_T_GO: begin
        goto_ra   = slot_addr(match_r, letter_r);
        state_nxt = S_T_INFO;
      end

      S_T_INFO: begin
        match_nxt = goto_rd;
        info_ra   = goto_rd;
        state_nxt = S_T_ACC;
      end

      S_T_ACC: begin
        here_nxt      = info_rd.out_cnt;
        rep_total_nxt = sum_tot;
        if (last_r) begin
          total_nxt = '0;
          match_nxt = '0;
        end else begin
          total_nxt = sum_tot;
        end
        state_nxt = S_DONE;
      end

      // build: root info, then the root is walked as the first node
      S_B_INIT: begin
        info_we   = 1'b1;
        info_wa   = '0;
        info_wd   = '0;
        head_nxt  = '0;
        tail_nxt  = '0;
        u_nxt     = '0;
        fu_nxt    = '0;
        j_nxt     = '0;
        root_nxt  = 1'b1;
        state_nxt = S_B_RD;
      end

      S_B_RD: begin
        child_ra  = slot_addr(u_r, j_r);
        goto_ra   = slot_addr(fu_r, j_r);
        state_nxt = S_B_EDGE;
      end

      // write the goto entry; a real child needs its link and count
      S_B_EDGE: begin
        goto_we = 1'b1;
        goto_wa = slot_addr(u_r, j_r);
        goto_wd = (child_rd != '0) ? child_rd : via_sel;
        if (child_rd != '0) begin
          c_nxt     = child_rd;
          via_nxt   = via_sel;
          endc_ra   = child_rd;
          info_ra   = via_sel;
          state_nxt = S_B_LINK;
        end else if (j_r == LAST_LET) begin
          state_nxt = S_B_POP;
        end else begin
          j_nxt     = j_r + LET_W'(1);
          state_nxt = S_B_RD;
        end
      end

      S_B_LINK: begin
        info_we         = 1'b1;
        info_wa         = c_r;
        info_wd.fail    = via_r;
        info_wd.out_cnt = sat_cnt(endc_rd, info_rd.out_cnt);
        if (tail_r < NODE_LIM) begin
          queue_we = 1'b1;
          queue_wa = tail_r[NODE_W-1:0];
          queue_wd = c_r;
          tail_nxt = tail_r + NTOT_W'(1);
        end
        if (j_r == LAST_LET) begin
          state_nxt = S_B_POP;
        end else begin
          j_nxt     = j_r + LET_W'(1);
          state_nxt = S_B_RD;
        end
      end

      // next node from the breadth-first queue
      S_B_POP: begin
        if (head_r < tail_r) begin
          queue_ra  = head_r[NODE_W-1:0];
          head_nxt  = head_r + NTOT_W'(1);
          state_nxt = S_B_U;
        end else begin
          match_nxt     = '0;
          total_nxt     = '0;
          built_nxt     = 1'b1;
          rep_total_nxt = '0;
          state_nxt     = S_DONE;
        end
      end

      S_B_U: begin
        u_nxt     = queue_rd;
        info_ra   = queue_rd;
        state_nxt = S_B_FU;
      end

      S_B_FU: begin
        fu_nxt    = info_rd.fail;
        j_nxt     = '0;
        root_nxt  = 1'b0;
        state_nxt = S_B_RD;
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.matches_here  = here_r;
          out_data_nxt.running_total = rep_total_r;
          out_data_nxt.nodes_used    = node_total_r;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      node_total_r <= NTOT_W'(1);
      insert_r     <= '0;
      match_r      <= '0;
      total_r      <= '0;
      built_r      <= 1'b0;
      clr_r        <= '0;
      clr_rep_r    <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_total_r <= node_total_nxt;
      insert_r     <= insert_nxt;
      match_r      <= match_nxt;
      total_r      <= total_nxt;
      built_r      <= built_nxt;
      clr_r        <= clr_nxt;
      clr_rep_r    <= clr_rep_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    letter_r    <= letter_nxt;
    last_r      <= last_nxt;
    status_r    <= status_nxt;
    here_r      <= here_nxt;
    rep_total_r <= rep_total_nxt;
    j_r         <= j_nxt;
    root_r      <= root_nxt;
    u_r         <= u_nxt;
    fu_r        <= fu_nxt;
    c_r         <= c_nxt;
    via_r       <= via_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // node count stays within the table
  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    (node_total_r >= NTOT_W'(1)) && (node_total_r <= NODE_LIM))
    else $error("node count out of range");

  // queue head never passes the tail
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head beyond tail");

  // a result only appears from the completion state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without completion");

  // an accepted request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("request accepted but not processed");

  // a text request before build leaves match state alone
  a_text_unbuilt: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.cmd == CMD_TEXT) && !built_r) |=> $stable(total_r))
    else $error("unbuilt text changed total");
`endif

endmodule
